// ----- sv/utf_pkg.sv -----
// ----------------------------------------------------------------------------
// utf_pkg: shared types and constants for the UTF-8 / UTF-16 transcoder
// Holds the job entry passed from the front end to the back end, the mode
// codes and the byte-class limits used by the decoder and encoder.
// ----------------------------------------------------------------------------
package utf_pkg;

  // Transcoding direction, as held in the direction register
  typedef enum logic {
    DIR_DECODE = 1'b0,
    DIR_ENCODE = 1'b1
  } dir_t;

  // Register index of the direction register
  localparam logic REG_DIRECTION = 1'b0;

  // Lead byte class limits
  localparam logic [7:0] LEAD1_MAX = 8'd127;
  localparam logic [7:0] LEAD2_MAX = 8'd223;
  localparam logic [7:0] LEAD3_MAX = 8'd239;

  // Code unit limits for encode
  localparam logic [15:0] ENC1_MAX = 16'h007f;
  localparam logic [15:0] ENC2_MAX = 16'h07ff;

  // UTF-8 marker bits
  localparam logic [7:0] MARK_LEAD2 = 8'hc0;
  localparam logic [7:0] MARK_LEAD3 = 8'he0;
  localparam logic [7:0] MARK_CONT  = 8'h80;

  // Payload masks
  localparam logic [7:0] MASK_CONT  = 8'h3f;
  localparam logic [7:0] MASK_LEAD2 = 8'h1f;
  localparam logic [7:0] MASK_LEAD3 = 8'h0f;

  // One queued job: one to three results to be sent
  typedef struct packed {
    logic [1:0]  cnt;      // number of results, 1..3
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [15:0] unit;
    logic        last;
    logic        bad;
  } job_t;

endpackage

// ----- sv/utf8_utf16_bmp_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf8_utf16_bmp_transcoder: UTF-8 to/from basic-plane UTF-16 transcoder
// Usage:
//   Input stream s_*: tdata holds in_byte [7:0] and in_unit [23:8], tlast
//   marks the last item of a buffer. Output stream m_*: tdata holds
//   out_byte [7:0] and out_unit [23:8], tuser holds seq_end [0] and
//   bad_lead [1], tlast is buffer_end.
//   The APB register at address 0 selects the direction: 0 decodes UTF-8
//   bytes to code units, 1 encodes code units to UTF-8. Write it only while
//   the block is idle; a write also drops any partial decode sequence.
//   A request reaches the output through the job queue and then the output
//   register. Decode takes one byte per cycle while the queue has room.
//   Encode sends one byte per cycle while the receiver is ready, so a unit
//   yields 1, 2 or 3 bytes, sent in turn by the serializer in the back end;
//   a short job queue absorbs these bursts and lets the input keep flowing.
//   Reset clears the direction (decode), the decode state, the queue and
//   the output valid flag. When the receiver holds m_tready low the output
//   register holds, the queue fills, and s_tready falls once it is full.
// ----------------------------------------------------------------------------
module utf8_utf16_bmp_transcoder
  import utf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_byte [7:0], in_unit [23:8]
  input  logic        s_tlast,   // in_last
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte [7:0], out_unit [23:8]
  output logic [1:0]  m_tuser,   // seq_end [0], bad_lead [1]
  output logic        m_tlast    // buffer_end
);

  dir_t direction;
  logic cfg_write;
  logic take;
  logic push;
  logic pop;
  logic empty;
  logic full;
  job_t new_job;
  job_t head;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
  assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_DECODE;
    end else if (cfg_write) begin
      direction <= dir_t'(pwdata[0]);
    end
  end

  // Accept a request whenever the queue has room
  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  utf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .dir       (direction),
    .cfg_clear (cfg_write),
    .take      (take),
    .in_byte   (s_tdata[7:0]),
    .in_unit   (s_tdata[23:8]),
    .in_last   (s_tlast),
    .push      (push),
    .job       (new_job)
  );

  utf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (new_job),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  utf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Encode results never carry a code unit or a bad-lead flag
  assert property (@(posedge clk) disable iff (rst)
    (push && direction == DIR_ENCODE) |-> (new_job.unit == 16'd0) && !new_job.bad)
    else $error("transcoder: encode job carries decode fields");

  // Decode jobs are always a single result with no byte
  assert property (@(posedge clk) disable iff (rst)
    (push && direction == DIR_DECODE) |-> (new_job.cnt == 2'd1) && (new_job.byte0 == 8'd0))
    else $error("transcoder: malformed decode job");

  // Every request is taken at once while the queue has room
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && !full) |-> take)
    else $error("transcoder: request not taken with queue space free");

endmodule

// ----- sv/utf_front.sv -----
// ----------------------------------------------------------------------------
// utf_front: request intake and classification
// Accepts one request per cycle while the queue has room, runs the UTF-8
// decode state and builds a job entry holding every result the request causes.
// ----------------------------------------------------------------------------
module utf_front
  import utf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dir_t        dir,
  input  logic        cfg_clear,
  input  logic        take,       // request accepted this cycle
  input  logic [7:0]  in_byte,
  input  logic [15:0] in_unit,
  input  logic        in_last,
  output logic        push,
  output job_t        job
);

  logic [1:0]  bytes_pending;
  logic [1:0]  bytes_pending_next;
  logic [9:0]  gathered_bits;
  logic [9:0]  gathered_bits_next;
  logic [15:0] acc;
  logic        emit;

  assign acc = {gathered_bits, in_byte[5:0]};

  // Classify the request and compute the decode state update
  always_comb begin
    job                = '0;
    job.last           = in_last;
    job.cnt            = 2'd1;
    emit               = 1'b0;
    bytes_pending_next = bytes_pending;
    gathered_bits_next = gathered_bits;
    if (dir == DIR_ENCODE) begin
      emit = 1'b1;
      if (in_unit <= ENC1_MAX) begin
        job.byte0 = in_unit[7:0];
      end else if (in_unit <= ENC2_MAX) begin
        job.cnt   = 2'd2;
        job.byte0 = MARK_LEAD2 | {3'b000, in_unit[10:6]};
        job.byte1 = MARK_CONT | {2'b00, in_unit[5:0]};
      end else begin
        job.cnt   = 2'd3;
        job.byte0 = MARK_LEAD3 | {4'b0000, in_unit[15:12]};
        job.byte1 = MARK_CONT | {2'b00, in_unit[11:6]};
        job.byte2 = MARK_CONT | {2'b00, in_unit[5:0]};
      end
    end else begin
      if (bytes_pending != 2'd0) begin
        bytes_pending_next = bytes_pending - 2'd1;
        if (bytes_pending_next == 2'd0) begin
          emit               = 1'b1;
          job.unit           = acc;
          gathered_bits_next = '0;
        end else begin
          gathered_bits_next = acc[9:0];
        end
      end else if (in_byte <= LEAD1_MAX) begin
        emit     = 1'b1;
        job.unit = {8'h00, in_byte};
      end else if (in_byte <= LEAD2_MAX) begin
        gathered_bits_next = {2'b00, in_byte & MASK_LEAD2};
        bytes_pending_next = 2'd1;
      end else if (in_byte <= LEAD3_MAX) begin
        gathered_bits_next = {2'b00, in_byte & MASK_LEAD3};
        bytes_pending_next = 2'd2;
      end else begin
        emit    = 1'b1;
        job.bad = 1'b1;
      end
      // Drop an unfinished sequence at the end of a buffer
      if (!emit && in_last) begin
        bytes_pending_next = '0;
        gathered_bits_next = '0;
      end
    end
  end

  assign push = take && emit;

  // Hold the decode state; clear it on reset and on a direction write
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      bytes_pending <= '0;
      gathered_bits <= '0;
    end else if (take) begin
      bytes_pending <= bytes_pending_next;
      gathered_bits <= gathered_bits_next;
    end
  end

  // A three-byte sequence never has more than two continuations pending
  assert property (@(posedge clk) disable iff (rst) bytes_pending != 2'd3)
    else $error("utf_front: bytes_pending out of range");

  // Encode requests leave the decode state alone
  assert property (@(posedge clk) disable iff (rst)
    (take && dir == DIR_ENCODE && !cfg_clear) |=>
      $stable(bytes_pending) && $stable(gathered_bits))
    else $error("utf_front: encode request changed decode state");

  // A finished sequence leaves no bits behind
  assert property (@(posedge clk) disable iff (rst)
    (bytes_pending == 2'd0) |-> (gathered_bits == 10'd0))
    else $error("utf_front: stale gathered bits");

endmodule

// ----- sv/utf_queue.sv -----
// ----------------------------------------------------------------------------
// utf_queue: short job queue between front and back end
// Register-based FIFO; the head entry is presented without a read latency.
// ----------------------------------------------------------------------------
module utf_queue
  import utf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("utf_queue: push while full");

  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("utf_queue: pop while empty");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("utf_queue: occupancy overflow");

endmodule

// ----- sv/utf_back.sv -----
// ----------------------------------------------------------------------------
// utf_back: result serializer and output register
// Sends the head job's results one per cycle unless the output stalls, pops it
// after the last one; the output register parts the queue from the receiver.
// ----------------------------------------------------------------------------
module utf_back
  import utf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte [7:0], out_unit [23:8]
  output logic [1:0]  m_tuser,   // seq_end [0], bad_lead [1]
  output logic        m_tlast    // buffer_end
);

  logic [1:0] idx;
  logic       load;
  logic       final_res;
  logic [7:0] sel_byte;

  assign load      = !empty && (!m_tvalid || m_tready);
  assign final_res = (idx == head.cnt - 2'd1);
  assign pop       = load && final_res;

  // Pick the byte for the current result
  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.byte0;
      2'd1:    sel_byte = head.byte1;
      default: sel_byte = head.byte2;
    endcase
  end

  // Step through the results of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= final_res ? 2'd0 : idx + 2'd1;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= !empty;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {head.unit, sel_byte};
      m_tuser <= {head.bad, final_res};
      m_tlast <= head.last && final_res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !empty |-> (idx < head.cnt))
    else $error("utf_back: result index past job length");

  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tlast |-> m_tuser[0])
    else $error("utf_back: buffer end on a non-final result");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == 24'd0))
    else $error("utf_back: bad-lead result carries data");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the UTF-8 / basic-plane UTF-16 transcoder
// Writes the direction register over APB between phases. Each phase queues
// bytes or code units: a directed set first, then random traffic. A
// transcoding model runs on every accepted request, and the monitor checks
// every output result against the oldest predicted one. Sender gaps,
// receiver stalls and one long receiver hold-off put pressure on the queue.
// ----------------------------------------------------------------------------
module tb_top;
  import utf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 6;
  localparam int RAND_ITEMS   = 72;

  // One input request and one output result, as the fields travel
  typedef struct packed {
    logic [7:0]  octet;
    logic [15:0] unit;
    logic        last;
  } char_req_t;

  typedef struct packed {
    logic [7:0]  octet;
    logic [15:0] unit;
    logic        seq_end;
    logic        buf_end;
    logic        bad;
  } char_out_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // in_byte [7:0], in_unit [23:8]
  logic        s_tlast  = 1'b0; // in_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // out_byte [7:0], out_unit [23:8]
  logic [1:0]  m_tuser;         // seq_end [0], bad_lead [1]
  logic        m_tlast;         // buffer_end

  // Transcoder model state
  dir_t        xc_dir   = DIR_DECODE;
  logic [1:0]  dec_left = '0;
  logic [9:0]  dec_acc  = '0;

  char_req_t   stream_feed[$];
  char_out_t   xcode_due[$];
  char_req_t   cur_req;
  char_out_t   mon_got;
  char_out_t   mon_want;

  int          queued_cnt   = 0;
  int          accepted_cnt = 0;
  int          results_cnt  = 0;
  int          bad_cnt      = 0;
  int          dir_writes   = 0;
  int          err_cnt      = 0;
  int          cyc          = 0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          hold_left    = 0;
  logic        hold_go      = 1'b0;
  logic        hold_done    = 1'b0;
  int          ph;

  utf8_utf16_bmp_transcoder dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void owe_result(input logic [7:0] octet, input logic [15:0] unit,
                                     input logic seq_end, input logic buf_end,
                                     input logic bad);
    xcode_due.push_back('{octet, unit, seq_end, buf_end, bad});
  endfunction

  // Predict the results of one accepted request and advance the decode state
  function automatic void transcode_req(input char_req_t r);
    logic [15:0] c;
    logic [15:0] acc;
    c   = r.unit;
    acc = {dec_acc, r.octet[5:0]};
    if (xc_dir == DIR_ENCODE) begin
      if (c <= ENC1_MAX) begin
        owe_result(c[7:0], 16'h0000, 1'b1, r.last, 1'b0);
      end else if (c <= ENC2_MAX) begin
        owe_result(MARK_LEAD2 | 8'(c >> 6), 16'h0000, 1'b0, 1'b0, 1'b0);
        owe_result(MARK_CONT | (c[7:0] & MASK_CONT), 16'h0000, 1'b1, r.last, 1'b0);
      end else begin
        owe_result(MARK_LEAD3 | 8'(c >> 12), 16'h0000, 1'b0, 1'b0, 1'b0);
        owe_result(MARK_CONT | (8'(c >> 6) & MASK_CONT), 16'h0000, 1'b0, 1'b0, 1'b0);
        owe_result(MARK_CONT | (c[7:0] & MASK_CONT), 16'h0000, 1'b1, r.last, 1'b0);
      end
      return;
    end
    if (dec_left != 2'd0) begin
      // any byte counts as a continuation while a sequence is open
      dec_left = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        dec_acc = '0;
        owe_result(8'h00, acc, 1'b1, r.last, 1'b0);
        return;
      end
      dec_acc = acc[9:0];
    end else if (r.octet <= LEAD1_MAX) begin
      owe_result(8'h00, {8'h00, r.octet}, 1'b1, r.last, 1'b0);
      return;
    end else if (r.octet <= LEAD2_MAX) begin
      dec_acc  = 10'(r.octet & MASK_LEAD2);
      dec_left = 2'd1;
    end else if (r.octet <= LEAD3_MAX) begin
      dec_acc  = 10'(r.octet & MASK_LEAD3);
      dec_left = 2'd2;
    end else begin
      owe_result(8'h00, 16'h0000, 1'b1, r.last, 1'b1);
      return;
    end
    // drop a sequence cut off by the end of the buffer
    if (r.last) begin
      dec_left = '0;
      dec_acc  = '0;
    end
  endfunction

  // Write the direction register; the write also clears the decode state
  task automatic set_direction(input dir_t d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DIRECTION, 2'b00};
    pwdata  <= {31'd0, d};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    xc_dir   = d;
    dec_left = '0;
    dec_acc  = '0;
    dir_writes++;
  endtask

  function automatic void add_req(input logic [7:0] octet, input logic [15:0] unit,
                                  input logic last);
    stream_feed.push_back('{octet, unit, last});
    queued_cnt++;
  endfunction

  // Decode requests carry a random unused unit, encode requests a random byte
  function automatic void add_dec(input logic [7:0] octet, input logic last);
    add_req(octet, 16'($urandom), last);
  endfunction

  function automatic void add_enc(input logic [15:0] unit, input logic last);
    add_req(8'($urandom), unit, last);
  endfunction

  function automatic logic one_in(input int odds);
    return $urandom_range(0, odds - 1) == 0;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  // Mostly well-formed UTF-8 with random content, some odd leads and noise
  task automatic gen_decode(input int n);
    int start;
    start = queued_cnt;
    while (queued_cnt - start < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_dec(8'($urandom_range(0, 127)), one_in(8));
        3, 4: begin
          add_dec(8'($urandom_range(8'hc2, 8'hdf)), one_in(30));
          add_dec(cont_byte(), one_in(8));
        end
        5: begin
          add_dec(8'($urandom_range(8'h80, 8'hc1)), one_in(30));
          add_dec(8'($urandom), one_in(8));
        end
        6, 7: begin
          add_dec(8'($urandom_range(8'he0, 8'hef)), one_in(30));
          add_dec(cont_byte(), one_in(30));
          add_dec(cont_byte(), one_in(8));
        end
        8: add_dec(8'($urandom_range(8'hf0, 8'hff)), one_in(8));
        default: add_dec(8'($urandom), one_in(8));
      endcase
    end
  endtask

  task automatic gen_encode(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: add_enc(16'($urandom_range(0, 16'h007f)), one_in(8));
        1: add_enc(16'($urandom_range(16'h0080, 16'h07ff)), one_in(8));
        2: add_enc(16'($urandom_range(16'h0800, 16'hffff)), one_in(8));
        default: add_enc(16'($urandom), one_in(8));
      endcase
    end
  endtask

  // Wait until every request is taken and every result has come back
  task automatic drain();
    while (accepted_cnt != queued_cnt || xcode_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: offer queued requests in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        transcode_req(cur_req);
        accepted_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (stream_feed.size() > 0) begin
          cur_req = stream_feed.pop_front();
          s_tdata  <= {cur_req.unit, cur_req.octet};
          s_tlast  <= cur_req.last;
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            gap_left   = one_in(3) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: one long hold-off on request, else a rotating stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case (cyc[9:8])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= one_in(2);
        2'd2: m_tready <= one_in(4);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  // Monitor: check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got = '{m_tdata[7:0], m_tdata[23:8], m_tuser[0], m_tlast, m_tuser[1]};
      results_cnt++;
      if (mon_got.bad) bad_cnt++;
      if (xcode_due.size() == 0) begin
        $error("result with none predicted: out_byte %0h out_unit %0h",
               mon_got.octet, mon_got.unit);
        err_cnt++;
      end else begin
        mon_want = xcode_due.pop_front();
        if (mon_got.octet !== mon_want.octet) begin
          $error("out_byte: expected %0h, got %0h", mon_want.octet, mon_got.octet);
          err_cnt++;
        end
        if (mon_got.unit !== mon_want.unit) begin
          $error("out_unit: expected %0h, got %0h", mon_want.unit, mon_got.unit);
          err_cnt++;
        end
        if (mon_got.seq_end !== mon_want.seq_end) begin
          $error("seq_end: expected %0b, got %0b", mon_want.seq_end, mon_got.seq_end);
          err_cnt++;
        end
        if (mon_got.buf_end !== mon_want.buf_end) begin
          $error("buffer_end: expected %0b, got %0b", mon_want.buf_end, mon_got.buf_end);
          err_cnt++;
        end
        if (mon_got.bad !== mon_want.bad) begin
          $error("bad_lead: expected %0b, got %0b", mon_want.bad, mon_got.bad);
          err_cnt++;
        end
      end
    end
  end

  // Sequence the phases
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed decode: every lead class, odd leads, unchecked continuation,
    // bad leads, a sequence cut by end of buffer, and one left open
    set_direction(DIR_DECODE);
    add_dec(8'h00, 1'b0);
    add_dec(8'h7f, 1'b0);
    add_dec(8'hc2, 1'b0); add_dec(8'ha9, 1'b0);
    add_dec(8'h80, 1'b0); add_dec(8'hbf, 1'b0);
    add_dec(8'hdf, 1'b0); add_dec(8'hbf, 1'b0);
    add_dec(8'he0, 1'b0); add_dec(8'h80, 1'b0); add_dec(8'h80, 1'b0);
    add_dec(8'hef, 1'b0); add_dec(8'hbf, 1'b0); add_dec(8'hbf, 1'b1);
    add_dec(8'hc3, 1'b0); add_dec(8'h41, 1'b0);
    add_dec(8'hf0, 1'b0);
    add_dec(8'hff, 1'b1);
    add_dec(8'he2, 1'b0); add_dec(8'h82, 1'b1);
    add_dec(8'h41, 1'b1);
    add_dec(8'he1, 1'b0); add_dec(8'h82, 1'b0);
    drain();

    // The register write must drop the open sequence: 0x85 starts afresh
    set_direction(DIR_DECODE);
    add_dec(8'h85, 1'b0); add_dec(8'h41, 1'b1);
    drain();

    // Directed encode: the edges of each length class and surrogates
    set_direction(DIR_ENCODE);
    add_enc(16'h0000, 1'b0);
    add_enc(16'h007f, 1'b1);
    add_enc(16'h0080, 1'b0);
    add_enc(16'h07ff, 1'b0);
    add_enc(16'h0800, 1'b1);
    add_enc(16'hd800, 1'b0);
    add_enc(16'hdfff, 1'b0);
    add_enc(16'hffff, 1'b1);
    add_enc(16'h1234, 1'b0);
    drain();

    // Random phases, alternating direction
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_direction(ph % 2 ? DIR_ENCODE : DIR_DECODE);
      if (ph % 2) gen_encode(RAND_ITEMS);
      else gen_decode(RAND_ITEMS);
      if (ph == 2) hold_go <= 1'b1;
      drain();
    end

    $display("Run covered %0d requests over %0d direction writes in both modes;",
             accepted_cnt, dir_writes);
    $display("%0d results checked, %0d of them bad-lead, %0d mismatches.",
             results_cnt, bad_cnt, err_cnt);
    if (err_cnt == 0 && xcode_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/utf_pkg.sv
sv/utf_front.sv
sv/utf_queue.sv
sv/utf_back.sv
sv/utf8_utf16_bmp_transcoder.sv
dv/tb_top.sv
